// ===== rtl/lfu_pkg.sv =====
// Shared types and constants for the LFU cache with LRU tie-break.
// Used by lfu_ctrl, lfu_dpath and the top level lfu_cache_lru_tiebreak.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int STAMP_W = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic latch;
        logic rd;
        logic commit;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/lfu_ctrl.sv =====
// Controller for the LFU cache: request handshake, entry scan sequencing
// and write-back timing. Depends on lfu_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module lfu_ctrl #(
    parameter int ENTRIES = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    output lfu_pkg::t_cmd                   o_cmd,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_rd_addr
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state          r_state;
    logic [IDXW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    if (i_start) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.latch  = (r_state == S_IDLE) && i_start;
        o_cmd.rd     = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT);
        o_busy       = (r_state != S_IDLE);
        o_rd_addr    = r_addr;
    end

endmodule

`default_nettype wire

// ===== rtl/lfu_dpath.sv =====
// Datapath for the LFU cache: entry storage, scan trackers for match,
// victim and free slot, write-back and result registers. Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfu_dpath #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire lfu_pkg::t_cmd                              i_cmd,
    input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_rd_addr,
    input  wire logic                                       i_cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0]                  i_cfg_wdata,
    input  wire logic                                       i_req_type,
    input  wire logic signed [lfu_pkg::KEY_W-1:0]           i_lookup_key,
    input  wire logic signed [lfu_pkg::VAL_W-1:0]           i_write_value,
    output logic                                            o_done,
    output logic                                            o_hit,
    output logic signed [lfu_pkg::VAL_W-1:0]                o_read_value,
    output logic                                            o_evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]                o_evicted_key
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int CMPW = (CNTW > lfu_pkg::CAP_W) ? CNTW : lfu_pkg::CAP_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

    logic [lfu_pkg::CAP_W-1:0]   r_capacity;
    logic                        r_req_put;
    logic [lfu_pkg::KEY_W-1:0]   r_key;
    logic [lfu_pkg::VAL_W-1:0]   r_wval;

    logic [ENTRIES-1:0]          r_valid;
    logic [lfu_pkg::KEY_W-1:0]   r_mem_key   [ENTRIES];
    logic [lfu_pkg::VAL_W-1:0]   r_mem_val   [ENTRIES];
    logic [COUNT_BITS-1:0]       r_mem_cnt   [ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0] r_mem_stamp [ENTRIES];

    logic                        r_rd_vld;
    logic [IDXW-1:0]             r_rd_idx;
    logic                        r_rd_entry_valid;
    logic [lfu_pkg::KEY_W-1:0]   r_rd_key;
    logic [lfu_pkg::VAL_W-1:0]   r_rd_val;
    logic [COUNT_BITS-1:0]       r_rd_cnt;
    logic [lfu_pkg::STAMP_W-1:0] r_rd_stamp;

    logic                        r_match_found;
    logic [IDXW-1:0]             r_match_idx;
    logic [lfu_pkg::VAL_W-1:0]   r_match_val;
    logic [COUNT_BITS-1:0]       r_match_cnt;
    logic [CNTW-1:0]             r_used;
    logic                        r_vict_found;
    logic [IDXW-1:0]             r_vict_idx;
    logic [COUNT_BITS-1:0]       r_vict_cnt;
    logic [lfu_pkg::STAMP_W-1:0] r_vict_stamp;
    logic [lfu_pkg::KEY_W-1:0]   r_vict_key;
    logic                        r_free_found;
    logic [IDXW-1:0]             r_free_idx;

    logic [lfu_pkg::STAMP_W-1:0] r_stamp_ctr;
    logic                        r_done;
    logic                        r_hit;
    logic [lfu_pkg::VAL_W-1:0]   r_read_value;
    logic                        r_evicted;
    logic [lfu_pkg::KEY_W-1:0]   r_evicted_key;

    logic                        proc;
    logic                        is_match;
    logic                        is_better;
    logic                        is_free;
    logic [CMPW-1:0]             cap_ext;
    logic [CMPW-1:0]             cap_eff;
    logic                        cap_on;
    logic                        do_touch;
    logic                        do_bump;
    logic                        do_upd;
    logic                        miss_put;
    logic                        do_evict;
    logic                        do_ins;
    logic [IDXW-1:0]             wr_idx;
    logic [COUNT_BITS-1:0]       wr_cnt;
    logic                        we_key;
    logic                        we_val;
    logic                        we_cnt;
    logic [lfu_pkg::VAL_W-1:0]   wr_val;

    always_comb begin
        proc      = r_rd_vld && r_rd_entry_valid;
        is_match  = proc && (r_rd_key == r_key) && !r_match_found;
        is_better = proc && (!r_vict_found || (r_rd_cnt < r_vict_cnt) ||
                    ((r_rd_cnt == r_vict_cnt) && (r_rd_stamp < r_vict_stamp)));
        is_free   = r_rd_vld && !r_rd_entry_valid && !r_free_found;

        cap_ext  = CMPW'(r_capacity);
        cap_eff  = (cap_ext > ENTRIES_C) ? ENTRIES_C : cap_ext;
        cap_on   = (cap_eff != '0);
        do_touch = r_match_found && ((r_req_put == lfu_pkg::REQ_GET) || cap_on);
        do_bump  = do_touch && (r_match_cnt != COUNT_MAX);
        do_upd   = (r_req_put == lfu_pkg::REQ_PUT) && cap_on && r_match_found;
        miss_put = (r_req_put == lfu_pkg::REQ_PUT) && cap_on && !r_match_found;
        do_evict = miss_put && (CMPW'(r_used) >= cap_eff) && r_vict_found;
        do_ins   = miss_put && (do_evict || r_free_found);
        wr_idx   = r_match_found ? r_match_idx : (do_evict ? r_vict_idx : r_free_idx);
        wr_cnt   = do_ins ? COUNT_BITS'(1) : (r_match_cnt + 1'b1);
        wr_val   = r_wval;
        we_key   = i_cmd.commit && do_ins;
        we_val   = i_cmd.commit && (do_ins || do_upd);
        we_cnt   = i_cmd.commit && (do_ins || do_bump);
    end

    always_ff @(posedge i_clk) begin
        if (we_key) begin
            r_mem_key[wr_idx] <= r_key;
        end
        if (we_val) begin
            r_mem_val[wr_idx] <= wr_val;
        end
        if (we_cnt) begin
            r_mem_cnt[wr_idx]   <= wr_cnt;
            r_mem_stamp[wr_idx] <= r_stamp_ctr;
        end
        if (i_cmd.rd) begin
            r_rd_key   <= r_mem_key[i_rd_addr];
            r_rd_val   <= r_mem_val[i_rd_addr];
            r_rd_cnt   <= r_mem_cnt[i_rd_addr];
            r_rd_stamp <= r_mem_stamp[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= lfu_pkg::CAP_RESET;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_stamp_ctr <= '0;
            r_done      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.rd;
            if (we_key) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (we_cnt) begin
                r_stamp_ctr <= r_stamp_ctr + 1'b1;
            end
            r_done <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx         <= i_rd_addr;
        r_rd_entry_valid <= r_valid[i_rd_addr];

        if (i_cmd.latch) begin
            r_req_put     <= i_req_type;
            r_key         <= $unsigned(i_lookup_key);
            r_wval        <= $unsigned(i_write_value);
            r_match_found <= 1'b0;
            r_vict_found  <= 1'b0;
            r_free_found  <= 1'b0;
            r_used        <= '0;
        end else begin
            if (is_match) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_rd_idx;
                r_match_val   <= r_rd_val;
                r_match_cnt   <= r_rd_cnt;
            end
            if (proc) begin
                r_used <= r_used + 1'b1;
            end
            if (is_better) begin
                r_vict_found <= 1'b1;
                r_vict_idx   <= r_rd_idx;
                r_vict_cnt   <= r_rd_cnt;
                r_vict_stamp <= r_rd_stamp;
                r_vict_key   <= r_rd_key;
            end
            if (is_free) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
        end

        if (i_cmd.commit) begin
            r_hit         <= r_match_found;
            r_read_value  <= ((r_req_put == lfu_pkg::REQ_GET) && r_match_found) ?
                             r_match_val : '0;
            r_evicted     <= do_evict;
            r_evicted_key <= do_evict ? r_vict_key : '0;
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_read_value  = $signed(r_read_value);
    assign o_evicted     = r_evicted;
    assign o_evicted_key = $signed(r_evicted_key);

    // A write-back cycle always produces exactly one result on the next cycle.
    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> o_done)
        else $error("result strobe missing after write-back");

    // An eviction only happens when the key was absent.
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_evicted))
        else $error("eviction reported on a hit");

    // A nonzero read value is only returned on a hit.
    a_read_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_read_value != '0)) |-> o_hit)
        else $error("read value returned on a miss");

    // The evicted key is zero unless an entry was removed.
    a_evkey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_evicted) |-> (o_evicted_key == '0))
        else $error("evicted key set without eviction");

endmodule

`default_nettype wire

// ===== rtl/lfu_cache_lru_tiebreak.sv =====
// Top level of the LFU key-value cache with least-recently-reached tie-break.
// Instantiates lfu_ctrl and lfu_dpath; depends on lfu_pkg.
//
// Usage: a request word (req_type, lookup_key, write_value) is taken at a
// rising edge where start is high and busy is low. A get (req_type 0) looks
// up the key; a put (req_type 1) updates or inserts it, evicting the entry
// with the lowest use count (oldest on ties) when the cache is at capacity.
// Exactly one result word is shown for one cycle with o_done high: o_hit,
// o_read_value, o_evicted and o_evicted_key. The receiver cannot stall it.
// Sequence: after the accepting edge the controller scans every entry, reading
// one entry per cycle through the single read port of the entry storage, then
// passes the drain and write-back states; the result strobe is registered from
// the write-back state. The word is taken at the edge that ends the strobe, and
// a new request may be accepted at that same edge, so one request is handled
// at a time.
// Capacity is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Reset clears all valid marks, the stamp counter and sets capacity to 16.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_req_type,
    input  wire logic signed [lfu_pkg::KEY_W-1:0]  i_lookup_key,
    input  wire logic signed [lfu_pkg::VAL_W-1:0]  i_write_value,
    output logic                                   o_done,
    output logic                                   o_hit,
    output logic signed [lfu_pkg::VAL_W-1:0]       o_read_value,
    output logic                                   o_evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]       o_evicted_key
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    lfu_pkg::t_cmd   cmd;
    logic [IDXW-1:0] rd_addr;

    lfu_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr)
    );

    lfu_dpath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

`default_nettype wire
